### hdl/gnt_pkg.sv
// ----------------------------------------------------------------------------
// Gradient noise turbulence package
// Widths, action and register codes, and the structs passed between the
// table store and the evaluation core.
// ----------------------------------------------------------------------------
package gnt_pkg;

   localparam int FRAC_BITS           = 16;
   localparam int GRAD_BITS           = 16;
   localparam int TABLE_SIZE          = 256;
   localparam int COORD_W             = 8 + FRAC_BITS;
   localparam int IDX_W               = 8;
   localparam int PERM_W              = 8;
   localparam int OUT_W               = 20;
   localparam int ACTION_W            = 2;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 4;
   localparam int OCT_REG_W           = 4;
   localparam int OCT_RESET           = 7;
   localparam int MAX_OCTAVES_DEFAULT = 8;
   localparam int OUT_MAX             = 524287;
   localparam int OUT_MIN             = -524288;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_GRAD = 2'd0,
      ACT_LOAD_PERM = 2'd1,
      ACT_EVAL      = 2'd2
   } action_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OCTAVES = 2'd1;

   typedef struct packed {
      logic                     perm_we;
      logic                     grad_we;
      logic [IDX_W-1:0]         addr;
      logic [PERM_W-1:0]        px;
      logic [PERM_W-1:0]        py;
      logic [PERM_W-1:0]        pz;
      logic [3*GRAD_BITS-1:0]   grad;
   } tbl_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0] ax;
      logic [IDX_W-1:0] ay;
      logic [IDX_W-1:0] az;
      logic [IDX_W-1:0] ag;
   } tbl_rd_type;

   typedef struct packed {
      logic [PERM_W-1:0]      px;
      logic [PERM_W-1:0]      py;
      logic [PERM_W-1:0]      pz;
      logic [3*GRAD_BITS-1:0] grad;
   } tbl_data_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_wr_type;

endpackage

### hdl/gradient_noise_turbulence_unit.sv
// ----------------------------------------------------------------------------
// Gradient noise turbulence unit
// 3-D gradient noise and turbulence over loadable lattice tables.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the req_ channel and are transferred when req_valid
// is high and req_stall is low. A load item writes one gradient entry or one
// entry in each of the three permutation tables in the cycle of its transfer
// and gives no result; loads can follow each other in every cycle. An
// evaluate item raises req_stall until its result has been placed in the
// output register, so the block works on one point at a time.
// Each octave works out the smoothstep weights of the three axes, then issues
// eight corner table reads, one a cycle, into a five stage read and multiply
// pipeline, then rounds the octave. A next item can be taken once the result
// is in the output register. The result waits in the output register while
// rsp_stall is high; a following item is still taken meanwhile and finishes
// its work, then waits for that register to empty.
// Configuration writes on the csr_ channel are always ready. Reset clears the
// control state and restores the register defaults; the tables stay
// undefined until loaded.
// ----------------------------------------------------------------------------
module gradient_noise_turbulence_unit #(
   parameter int MAX_OCTAVES = gnt_pkg::MAX_OCTAVES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [gnt_pkg::ACTION_W-1:0]           req_action,
   input  logic [gnt_pkg::IDX_W-1:0]              req_table_index,
   input  logic signed [gnt_pkg::GRAD_BITS-1:0]   req_grad_x,
   input  logic signed [gnt_pkg::GRAD_BITS-1:0]   req_grad_y,
   input  logic signed [gnt_pkg::GRAD_BITS-1:0]   req_grad_z,
   input  logic [gnt_pkg::PERM_W-1:0]             req_perm_x_value,
   input  logic [gnt_pkg::PERM_W-1:0]             req_perm_y_value,
   input  logic [gnt_pkg::PERM_W-1:0]             req_perm_z_value,
   input  logic [gnt_pkg::COORD_W-1:0]            req_coord_x,
   input  logic [gnt_pkg::COORD_W-1:0]            req_coord_y,
   input  logic [gnt_pkg::COORD_W-1:0]            req_coord_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [gnt_pkg::OUT_W-1:0]       rsp_noise_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gnt_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [gnt_pkg::CSR_DATA_W-1:0]         csr_data
);
   import gnt_pkg::*;

   logic         busy;
   logic         req_transfer;
   tbl_wr_type   tbl_wr;
   tbl_rd_type   tbl_rd;
   tbl_data_type tbl_data;
   csr_wr_type   csr_wr;

   assign req_stall    = busy;
   assign req_transfer = req_valid && !busy;
   assign csr_ready    = 1'b1;

   // Loads go straight into the tables; the core only reads them while busy,
   // so a read never meets a write to the same entry.
   always_comb begin
      tbl_wr.perm_we = req_transfer && (req_action == ACT_LOAD_PERM);
      tbl_wr.grad_we = req_transfer && (req_action == ACT_LOAD_GRAD);
      tbl_wr.addr    = req_table_index;
      tbl_wr.px      = req_perm_x_value;
      tbl_wr.py      = req_perm_y_value;
      tbl_wr.pz      = req_perm_z_value;
      tbl_wr.grad    = {req_grad_x, req_grad_y, req_grad_z};
      csr_wr.valid   = csr_valid;
      csr_wr.index   = csr_index;
      csr_wr.data    = csr_data;
   end

   gnt_tables u_tables (
      .clock (clock),
      .wr    (tbl_wr),
      .rd    (tbl_rd),
      .rdata (tbl_data)
   );

   gnt_core #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .start           (req_transfer && (req_action == ACT_EVAL)),
      .coord_x         (req_coord_x),
      .coord_y         (req_coord_y),
      .coord_z         (req_coord_z),
      .csr             (csr_wr),
      .busy            (busy),
      .rd              (tbl_rd),
      .rdata           (tbl_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

### hdl/gnt_tables.sv
// ----------------------------------------------------------------------------
// Gradient noise table store
// Three permutation memories and the gradient memory, each with one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module gnt_tables (
   input  logic                  clock,
   input  gnt_pkg::tbl_wr_type   wr,
   input  gnt_pkg::tbl_rd_type   rd,
   output gnt_pkg::tbl_data_type rdata
);
   import gnt_pkg::*;

   logic [PERM_W-1:0]      perm_x_mem [TABLE_SIZE];
   logic [PERM_W-1:0]      perm_y_mem [TABLE_SIZE];
   logic [PERM_W-1:0]      perm_z_mem [TABLE_SIZE];
   logic [3*GRAD_BITS-1:0] grad_mem   [TABLE_SIZE];
   tbl_data_type           rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.perm_we) begin
         perm_x_mem[wr.addr] <= wr.px;
         perm_y_mem[wr.addr] <= wr.py;
         perm_z_mem[wr.addr] <= wr.pz;
      end
      if (wr.grad_we) begin
         grad_mem[wr.addr] <= wr.grad;
      end
      rdata_ff.px   <= perm_x_mem[rd.ax];
      rdata_ff.py   <= perm_y_mem[rd.ay];
      rdata_ff.pz   <= perm_z_mem[rd.az];
      rdata_ff.grad <= grad_mem[rd.ag];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/gnt_core.sv
// ----------------------------------------------------------------------------
// Gradient noise evaluation core
// Octave sequencer, smoothstep unit, corner pipeline and result register.
// ----------------------------------------------------------------------------
module gnt_core #(
   parameter int MAX_OCTAVES = gnt_pkg::MAX_OCTAVES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [gnt_pkg::COORD_W-1:0]         coord_x,
   input  logic [gnt_pkg::COORD_W-1:0]         coord_y,
   input  logic [gnt_pkg::COORD_W-1:0]         coord_z,
   input  gnt_pkg::csr_wr_type                 csr,
   output logic                                busy,
   output gnt_pkg::tbl_rd_type                 rd,
   input  gnt_pkg::tbl_data_type               rdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [gnt_pkg::OUT_W-1:0]    rsp_noise_value
);
   import gnt_pkg::*;

   localparam int ONE      = 1 << FRAC_BITS;
   localparam int HALF     = 1 << (FRAC_BITS - 1);
   localparam int W_W      = FRAC_BITS + 1;
   localparam int OFS_W    = FRAC_BITS + 2;
   localparam int DOT_W    = GRAD_BITS + OFS_W + 2;
   localparam int DQ_SH    = GRAD_BITS - 2;
   localparam int DQ_W     = DOT_W - DQ_SH;
   localparam int PROD_W   = DQ_W + W_W + 1;
   localparam int SUM_W    = PROD_W + 3;
   localparam int NOISE_W  = SUM_W - FRAC_BITS;
   localparam int ACC_W    = NOISE_W + MAX_OCTAVES + 1;
   localparam int CNT_W    = $clog2(MAX_OCTAVES + 1);
   localparam int ACC_FRAC = MAX_OCTAVES - 1;
   localparam int ACC_RND  = (MAX_OCTAVES > 1) ? (1 << (MAX_OCTAVES - 2)) : 0;
   localparam int SM_W     = 2 * FRAC_BITS + 4;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SMOOTH,
      ST_CORNER,
      ST_OCTAVE,
      ST_FINAL,
      ST_FINISH
   } state_type;

   function automatic logic [OUT_W-1:0] saturate(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      begin
         c = v;
         if (v > SAT_HI) c = SAT_HI;
         if (v < SAT_LO) c = SAT_LO;
         return c[OUT_W-1:0];
      end
   endfunction

   // Sequencer state
   state_type                state_ff;
   logic                     mode_ff;
   logic [OCT_REG_W-1:0]     octaves_ff;
   logic [COORD_W-1:0]       cx_ff, cy_ff, cz_ff;
   logic [CNT_W-1:0]         n_ff, oct_ff;
   logic [2:0]               step_ff;
   logic [W_W-1:0]           u2_ff;
   logic [W_W-1:0]           s_ff [3];
   logic [3:0]               corner_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [OUT_W-1:0]         result_ff;
   logic                     rsp_valid_ff;
   logic [OUT_W-1:0]         rsp_noise_ff;

   // Corner pipeline
   logic                     p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic [2:0]               p1_c_ff, p2_c_ff;
   logic signed [DOT_W-1:0]  dot_ff;
   logic [W_W-1:0]           wxy_ff, wz_ff, w_ff;
   logic signed [DQ_W-1:0]   dq_ff;
   logic signed [PROD_W-1:0] prod_ff;

   // Smoothstep unit, one axis at a time over two steps
   logic [1:0]               axis;
   logic [FRAC_BITS-1:0]     u;
   logic [2*FRAC_BITS:0]     sq;
   logic [W_W-1:0]           u2_in, s_in;
   logic [FRAC_BITS+1:0]     tt;
   logic [SM_W-1:0]          sm;

   always_comb begin
      axis = step_ff[2:1];
      case (axis)
         2'd0:    u = cx_ff[FRAC_BITS-1:0];
         2'd1:    u = cy_ff[FRAC_BITS-1:0];
         default: u = cz_ff[FRAC_BITS-1:0];
      endcase
      sq    = (2*FRAC_BITS+1)'(u) * (2*FRAC_BITS+1)'(u) + (2*FRAC_BITS+1)'(HALF);
      u2_in = W_W'(sq >> FRAC_BITS);
      tt    = (FRAC_BITS+2)'(3 * ONE) - {1'b0, u, 1'b0};
      sm    = SM_W'(u2_ff) * SM_W'(tt) + (SM_W'(1) << (2*FRAC_BITS - 1));
      s_in  = W_W'(sm >> (2*FRAC_BITS));
   end

   // Corner issue and table addressing
   logic       issue;
   logic [2:0] cb;
   logic       pipe_busy;

   assign issue     = (state_ff == ST_CORNER) && !corner_ff[3];
   assign cb        = corner_ff[2:0];
   assign pipe_busy = p1_v_ff | p2_v_ff | p3_v_ff | p4_v_ff | p5_v_ff;

   always_comb begin
      rd.ax = IDX_W'(cx_ff[COORD_W-1:FRAC_BITS]) + IDX_W'(cb[2]);
      rd.ay = IDX_W'(cy_ff[COORD_W-1:FRAC_BITS]) + IDX_W'(cb[1]);
      rd.az = IDX_W'(cz_ff[COORD_W-1:FRAC_BITS]) + IDX_W'(cb[0]);
      rd.ag = rdata.px ^ rdata.py ^ rdata.pz;
   end

   // Stage two: dot product and first weight product
   logic signed [GRAD_BITS-1:0] gx, gy, gz;
   logic signed [OFS_W-1:0]     ox, oy, oz;
   logic [W_W-1:0]              wx, wy, wz;
   logic [2*W_W:0]              wxy_p;
   logic signed [DOT_W-1:0]     dot_in;

   always_comb begin
      gx = rdata.grad[3*GRAD_BITS-1:2*GRAD_BITS];
      gy = rdata.grad[2*GRAD_BITS-1:GRAD_BITS];
      gz = rdata.grad[GRAD_BITS-1:0];
      ox = $signed(OFS_W'(cx_ff[FRAC_BITS-1:0])) - (p2_c_ff[2] ? OFS_W'(ONE) : '0);
      oy = $signed(OFS_W'(cy_ff[FRAC_BITS-1:0])) - (p2_c_ff[1] ? OFS_W'(ONE) : '0);
      oz = $signed(OFS_W'(cz_ff[FRAC_BITS-1:0])) - (p2_c_ff[0] ? OFS_W'(ONE) : '0);
      dot_in = DOT_W'(gx) * DOT_W'(ox) + DOT_W'(gy) * DOT_W'(oy) + DOT_W'(gz) * DOT_W'(oz);
      wx = p2_c_ff[2] ? s_ff[0] : W_W'(ONE) - s_ff[0];
      wy = p2_c_ff[1] ? s_ff[1] : W_W'(ONE) - s_ff[1];
      wz = p2_c_ff[0] ? s_ff[2] : W_W'(ONE) - s_ff[2];
      wxy_p = (2*W_W+1)'(wx) * (2*W_W+1)'(wy) + (2*W_W+1)'(HALF);
   end

   // Stage three: rounding of the dot product and full corner weight
   logic signed [DOT_W-1:0] dot_rnd;
   logic signed [DQ_W-1:0]  dq_in;
   logic [2*W_W:0]          w_p;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      dot_rnd = dot_ff + $signed(DOT_W'(1 << (DQ_SH - 1)));
      dq_in   = DQ_W'(dot_rnd >>> DQ_SH);
      w_p     = (2*W_W+1)'(wxy_ff) * (2*W_W+1)'(wz_ff) + (2*W_W+1)'(HALF);
      prod_in = PROD_W'(dq_ff) * $signed(PROD_W'(w_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= issue;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         p4_v_ff <= p3_v_ff;
         p5_v_ff <= p4_v_ff;
      end
      p1_c_ff <= cb;
      p2_c_ff <= p1_c_ff;
      dot_ff  <= dot_in;
      wxy_ff  <= W_W'(wxy_p >> FRAC_BITS);
      wz_ff   <= wz;
      dq_ff   <= dq_in;
      w_ff    <= W_W'(w_p >> FRAC_BITS);
      prod_ff <= prod_in;
   end

   // Octave and final result arithmetic
   logic signed [SUM_W-1:0]  sum_rnd;
   logic signed [NOISE_W-1:0] noise_in;
   logic [CNT_W-1:0]         sh;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_rnd, r_in;
   logic [CNT_W-1:0]         n_sel;
   logic [CNT_W-1:0]         oct_next;

   always_comb begin
      sum_rnd  = sum_ff + $signed(SUM_W'(HALF));
      noise_in = NOISE_W'(sum_rnd >>> FRAC_BITS);
      sh       = CNT_W'(ACC_FRAC) - oct_ff;
      acc_in   = acc_ff + (ACC_W'(noise_in) <<< sh);
      acc_rnd  = acc_ff + $signed(ACC_W'(ACC_RND));
      r_in     = acc_rnd >>> ACC_FRAC;
      if (r_in < 0) r_in = -r_in;
      n_sel    = (int'(octaves_ff) > MAX_OCTAVES) ? CNT_W'(MAX_OCTAVES) : CNT_W'(octaves_ff);
      oct_next = oct_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= 1'b0;
         octaves_ff   <= OCT_REG_W'(OCT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            case (csr.index)
               CSR_MODE:    mode_ff    <= csr.data[0];
               CSR_OCTAVES: octaves_ff <= csr.data;
               default:     ;
            endcase
         end
         // In the finishing state the output register is handled below.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cx_ff   <= coord_x;
                  cy_ff   <= coord_y;
                  cz_ff   <= coord_z;
                  oct_ff  <= '0;
                  acc_ff  <= '0;
                  step_ff <= '0;
                  if (!mode_ff) begin
                     n_ff     <= CNT_W'(1);
                     state_ff <= ST_SMOOTH;
                  end else begin
                     n_ff     <= n_sel;
                     state_ff <= (n_sel == '0) ? ST_FINAL : ST_SMOOTH;
                  end
               end
            end
            ST_SMOOTH: begin
               if (!step_ff[0]) begin
                  u2_ff <= u2_in;
               end else begin
                  s_ff[axis] <= s_in;
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd5) begin
                  corner_ff <= '0;
                  sum_ff    <= '0;
                  state_ff  <= ST_CORNER;
               end
            end
            ST_CORNER: begin
               if (issue) begin
                  corner_ff <= corner_ff + 4'd1;
               end
               if (p5_v_ff) begin
                  sum_ff <= sum_ff + SUM_W'(prod_ff);
               end
               if (corner_ff[3] && !pipe_busy) begin
                  state_ff <= ST_OCTAVE;
               end
            end
            ST_OCTAVE: begin
               if (!mode_ff) begin
                  result_ff <= saturate(ACC_W'(noise_in));
                  state_ff  <= ST_FINISH;
               end else begin
                  acc_ff  <= acc_in;
                  cx_ff   <= cx_ff << 1;
                  cy_ff   <= cy_ff << 1;
                  cz_ff   <= cz_ff << 1;
                  oct_ff  <= oct_next;
                  step_ff <= '0;
                  state_ff <= (oct_next == n_ff) ? ST_FINAL : ST_SMOOTH;
               end
            end
            ST_FINAL: begin
               result_ff <= saturate(r_in);
               state_ff  <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_noise_ff <= result_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = $signed(rsp_noise_ff);

endmodule

### hdl/gnt_checker.sv
// ----------------------------------------------------------------------------
// Gradient noise turbulence checker
// Port-level assertions on transfer ordering, bound to the top level.
// ----------------------------------------------------------------------------
module gnt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [gnt_pkg::ACTION_W-1:0]       req_action,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [gnt_pkg::OUT_W-1:0]   rsp_noise_value
);
   import gnt_pkg::*;

   // A held result keeps its value until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("result changed while stalled");

   // An evaluation keeps the input side stalled in the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_EVAL) |=> req_stall)
      else $error("no stall after an evaluation transfer");

   // Loads never hold up the input side.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      ((req_action == ACT_LOAD_GRAD) || (req_action == ACT_LOAD_PERM)) |=> !req_stall)
      else $error("stall after a load transfer");

   // A new result only appears at the end of an evaluation.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an evaluation");

endmodule

bind gradient_noise_turbulence_unit gnt_checker u_checker (.*);

### test/tb_gradient_noise_turbulence_unit.sv
// ----------------------------------------------------------------------------
// Gradient noise turbulence unit testbench
// Loads the lattice tables, evaluates points in plain and turbulence mode at
// several register settings, and checks every result against a predictor.
// ----------------------------------------------------------------------------
module tb_gradient_noise_turbulence_unit;
   import gnt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_OCTAVES = MAX_OCTAVES_DEFAULT;
   localparam int IDLE_LIMIT  = 20000;
   // Permutation entries keep to six bits, so every hash stays below
   // GRAD_FILL and only that many gradient entries need loading.
   localparam int GRAD_FILL   = 64;
   localparam logic [23:0] PERM_MASK = 24'h3f3f3f;

   // The scoreboard keeps its own copy of the tables and registers, works out
   // the noise value of each evaluate transfer and holds it until it returns.
   class noise_scoreboard;
      logic signed [GRAD_BITS-1:0] grad_mem [TABLE_SIZE][3];
      logic [PERM_W-1:0]           perm_mem [3][TABLE_SIZE];
      logic                        turb_mode;
      logic [OCT_REG_W-1:0]        octaves;
      logic signed [OUT_W-1:0]     pending_noise [$];
      int                          errors;

      function void clear();
         foreach (grad_mem[i, a]) grad_mem[i][a] = '0;
         foreach (perm_mem[a, i]) perm_mem[a][i] = '0;
         turb_mode = 1'b0;
         octaves   = OCT_REG_W'(OCT_RESET);
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_MODE) turb_mode = val[0];
         else if (idx == CSR_OCTAVES) octaves = val[OCT_REG_W-1:0];
      endfunction

      // Rounds to nearest with ties toward plus infinity; >>> floors.
      function longint rnd(longint x, int sh);
         return (x + (longint'(1) << (sh - 1))) >>> sh;
      endfunction

      function longint smoothstep(longint u);
         longint u2;
         u2 = (u * u + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         return (u2 * ((3 << FRAC_BITS) - 2 * u) + (longint'(1) << (2 * FRAC_BITS - 1)))
                >> (2 * FRAC_BITS);
      endfunction

      function longint one_octave(logic [COORD_W-1:0] c [3]);
         longint frac [3], sw [3], off [3], w, dq, sum, one;
         logic [7:0] lat [3];
         logic [7:0] h;
         int d [3];
         one = longint'(1) << FRAC_BITS;
         sum = 0;
         for (int a = 0; a < 3; a++) begin
            frac[a] = c[a][FRAC_BITS-1:0];
            lat[a]  = c[a][COORD_W-1:FRAC_BITS];
            sw[a]   = smoothstep(frac[a]);
         end
         for (int k = 0; k < 8; k++) begin
            d[0] = (k >> 2) & 1;
            d[1] = (k >> 1) & 1;
            d[2] = k & 1;
            h = perm_mem[0][8'(lat[0] + d[0])] ^ perm_mem[1][8'(lat[1] + d[1])]
                ^ perm_mem[2][8'(lat[2] + d[2])];
            dq = 0;
            w  = one;
            for (int a = 0; a < 3; a++) begin
               off[a] = frac[a] - (d[a] ? one : 0);
               dq += longint'(grad_mem[h][a]) * off[a];
            end
            dq = rnd(dq, GRAD_BITS - 2);
            w  = ((d[0] ? sw[0] : one - sw[0]) * (d[1] ? sw[1] : one - sw[1])
                  + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            w  = (w * (d[2] ? sw[2] : one - sw[2]) + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            sum += dq * w;
         end
         return rnd(sum, FRAC_BITS);
      endfunction

      // Notes an accepted input transfer: loads update the tables, an evaluate
      // queues its expected result.
      function void note_request(action_type act, logic [IDX_W-1:0] idx,
                                 logic signed [GRAD_BITS-1:0] g [3],
                                 logic [PERM_W-1:0] p [3],
                                 logic [COORD_W-1:0] c [3]);
         longint acc, r;
         int n;
         case (act)
            ACT_LOAD_GRAD: begin
               for (int a = 0; a < 3; a++) grad_mem[idx][a] = g[a];
            end
            ACT_LOAD_PERM: begin
               for (int a = 0; a < 3; a++) perm_mem[a][idx] = p[a];
            end
            ACT_EVAL: begin
               if (!turb_mode) begin
                  r = one_octave(c);
               end else begin
                  n   = (octaves > NUM_OCTAVES) ? NUM_OCTAVES : octaves;
                  acc = 0;
                  for (int o = 0; o < n; o++) begin
                     acc += one_octave(c) * (longint'(1) << (NUM_OCTAVES - 1 - o));
                     for (int a = 0; a < 3; a++) c[a] = c[a] << 1;
                  end
                  r = rnd(acc, NUM_OCTAVES - 1);
                  if (r < 0) r = -r;
               end
               if (r > OUT_MAX) r = OUT_MAX;
               if (r < OUT_MIN) r = OUT_MIN;
               pending_noise.push_back(OUT_W'(r));
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic signed [OUT_W-1:0] got);
         logic signed [OUT_W-1:0] want;
         if (pending_noise.size() == 0) begin
            $error("noise_value: result %0d arrived with none expected", got);
            errors++;
            return;
         end
         want = pending_noise.pop_front();
         if (got !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [ACTION_W-1:0]         req_action = '0;
   logic [IDX_W-1:0]            req_table_index = '0;
   logic signed [GRAD_BITS-1:0] req_grad_x = '0, req_grad_y = '0, req_grad_z = '0;
   logic [PERM_W-1:0]           req_perm_x_value = '0, req_perm_y_value = '0;
   logic [PERM_W-1:0]           req_perm_z_value = '0;
   logic [COORD_W-1:0]          req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [OUT_W-1:0]     rsp_noise_value;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_data = '0;

   noise_scoreboard board = new();
   int  idle_cycles = 0;
   bit  stall_enable = 1'b1;
   bit  hold_output = 1'b0;
   bit  gaps_enable = 1'b1;

   gradient_noise_turbulence_unit dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Every accepted input transfer goes to the scoreboard, every accepted
   // result is checked, and the watchdog counts cycles with no transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_request(action_type'(req_action), req_table_index,
                               '{req_grad_x, req_grad_y, req_grad_z},
                               '{req_perm_x_value, req_perm_y_value, req_perm_z_value},
                               '{req_coord_x, req_coord_y, req_coord_z});
         end
         if (rsp_valid && !rsp_stall) board.check_result(rsp_noise_value);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // The receiver stalls in random bursts; a long hold lets the block fill up
   // and stall its input while the sender keeps offering items.
   initial begin
      int run;
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_stall <= 1'b1;
         end else if (stall_enable && $urandom_range(0, 3) == 0) begin
            run = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
            repeat (run - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [47:0] rand_grad();
      return {16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   function automatic logic [23:0] rand_perm();
      return 24'($urandom) & PERM_MASK;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   // Offers one item and holds it until it is transferred. The gap before it
   // is drawn at random, so idle cycles fall on every phase of the block.
   task automatic send_item(action_type act, logic [IDX_W-1:0] idx,
                            logic [47:0] grad, logic [23:0] perm,
                            logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                            logic [COORD_W-1:0] cz);
      if (gaps_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_table_index  <= idx;
      {req_grad_x, req_grad_y, req_grad_z} <= grad;
      {req_perm_x_value, req_perm_y_value, req_perm_z_value} <= perm;
      req_coord_x      <= cx;
      req_coord_y      <= cy;
      req_coord_z      <= cz;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_point(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [COORD_W-1:0] cz);
      send_item(ACT_EVAL, 8'($urandom), rand_grad(), 24'($urandom), cx, cy, cz);
   endtask

   // Coordinates near cell edges in half the picks, fully random values in the rest.
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return {8'($urandom), 16'h0000} ^ COORD_W'($urandom_range(0, 3));
         1: return {8'($urandom), 16'hffff} - COORD_W'($urandom_range(0, 3));
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic send_random(int count, bit with_noise);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (with_noise && pick == 0) begin
            send_item(ACT_LOAD_GRAD, 8'($urandom), rand_grad(), 24'($urandom), '0, '0, '0);
         end else if (with_noise && pick == 1) begin
            send_item(ACT_LOAD_PERM, 8'($urandom), rand_grad(), rand_perm(), '0, '0, '0);
         end else if (with_noise && pick == 2) begin
            // The unused action is ignored by the block and gives no result.
            send_item(action_type'(2'd3), 8'($urandom), rand_grad(), 24'($urandom),
                      COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            i--;
         end else begin
            send_point(pick_coord(), pick_coord(), pick_coord());
         end
      end
   endtask

   // Waits until every expected result has arrived, then lets the block's
   // latency pass so that no evaluate is still in flight.
   task automatic drain();
      req_valid <= 1'b0;
      wait (board.pending_noise.size() == 0);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      board.clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every entry that an evaluate can reach, so none reads an
      // unwritten one.
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (i < GRAD_FILL) begin
            send_item(ACT_LOAD_GRAD, 8'(i), rand_grad(), 24'($urandom), '0, '0, '0);
         end
         send_item(ACT_LOAD_PERM, 8'(i), rand_grad(), rand_perm(), '0, '0, '0);
      end
      // Extreme gradients and permutation entries at both ends of the tables.
      send_item(ACT_LOAD_GRAD, 8'd0, {3{16'h8000}}, 24'h0, '0, '0, '0);
      send_item(ACT_LOAD_GRAD, 8'(GRAD_FILL - 1), {3{16'h7fff}}, 24'h0, '0, '0, '0);
      send_item(ACT_LOAD_PERM, 8'd0, 48'h0, 24'h000000, '0, '0, '0);
      send_item(ACT_LOAD_PERM, 8'd255, 48'h0, PERM_MASK, '0, '0, '0);

      // Directed points in plain mode: origin, cell edges and the wrap at 256.
      send_point(24'h000000, 24'h000000, 24'h000000);
      send_point(24'hffffff, 24'hffffff, 24'hffffff);
      send_point(24'h008000, 24'h008000, 24'h008000);
      send_point(24'hff0000, 24'h00ffff, 24'h800001);
      send_point(24'h7fffff, 24'h800000, 24'h000001);
      send_item(action_type'(2'd3), 8'hff, {48{1'b1}}, 24'hffffff, '1, '1, '1);
      drain();

      // Turbulence at the extremes of the octave count and at one octave.
      write_csr(CSR_MODE, 4'd1);
      write_csr(CSR_OCTAVES, 4'd8);
      send_point(24'hffffff, 24'hffffff, 24'hffffff);
      send_point(24'h7fffff, 24'h008000, 24'h000000);
      drain();
      write_csr(CSR_OCTAVES, 4'd15);
      send_point(24'h123456, 24'habcdef, 24'h00ffff);
      drain();
      write_csr(CSR_OCTAVES, 4'd0);
      send_point(24'h123456, 24'habcdef, 24'h00ffff);
      drain();
      write_csr(CSR_OCTAVES, 4'd1);
      send_point(24'h008000, 24'hff8000, 24'h010000);
      drain();

      // Random phases, each at its own register setting.
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(CSR_MODE, CSR_DATA_W'(phase[0]));
         write_csr(CSR_OCTAVES, (phase == 5) ? 4'd1 : 4'($urandom_range(1, 8)));
         send_random(phase[0] ? 15 : 25, 1'b1);
         if (phase == 2) begin
            // The sender pauses until every expected result has come.
            req_valid <= 1'b0;
            wait (board.pending_noise.size() == 0);
         end
         if (phase == 3) begin
            // Long hold on the output while the sender keeps offering items.
            hold_output = 1'b1;
            fork
               begin
                  repeat (800) @(posedge clock);
                  hold_output = 1'b0;
               end
               send_random(5, 1'b0);
            join
         end
         drain();
      end

      // Last part of the run with no idling on either side.
      stall_enable = 1'b0;
      gaps_enable  = 1'b0;
      write_csr(CSR_MODE, 4'd0);
      send_random(30, 1'b1);
      drain();

      if (board.errors == 0 && board.pending_noise.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
